[src/lru_key_value_cache_core_defines.svh]
// Assertion macros for the checker file.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define LKV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lkv assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define LKV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lkv assertion failed");

`endif

[src/lkv_pkg.sv]
package lkv_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int IN_KEY_BITS    = 32;
    localparam int IN_VALUE_BITS  = 32;

    localparam int PADDR_BITS     = 3;
    localparam int PDATA_BITS     = 32;
    localparam int CAP_BITS       = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // word index of the capacity register (paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                            mode;
        logic        [IN_KEY_BITS-1:0]   lookup_key;
        logic signed [IN_VALUE_BITS-1:0] write_value;
    } in_t;

    typedef struct packed {
        logic                            found;
        logic signed [IN_VALUE_BITS-1:0] read_value;
        logic                            evicted;
    } out_t;

endpackage

[src/lru_key_value_cache_core.sv]
// Each input beat scans the key/rank RAMs one entry per cycle; for a hit or a put a
// second rank RAM pass then ages entries, which a get miss skips. The result then
// waits for the result register to drain. One item is taken at a time: s_ready stays
// low from an input beat until its result is loaded into the result register.
// Reset (aresetn low, synchronous): valid bits and occupancy clear at once,
// no clearing pass; capacity returns to 16; key/value/rank RAMs keep content.
module lru_key_value_cache_core
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CAPW = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_DECIDE   = 3'd3;
    localparam logic [2:0] ST_PROM     = 3'd4;
    localparam logic [2:0] ST_PROM_END = 3'd5;
    localparam logic [2:0] ST_RANK0    = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [IW-1:0]         rd_idx_reg, rd_idx_next;
    logic                  pipe_valid_reg, pipe_valid_next;
    logic [IW-1:0]         pipe_idx_reg, pipe_idx_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [CW-1:0]         occ_reg, occ_next;
    logic [CAP_BITS-1:0]   cap_reg, cap_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    logic                  mode_reg, mode_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  hit_found_reg, hit_found_next;
    logic [IW-1:0]         hit_idx_reg, hit_idx_next;
    logic [IW-1:0]         hit_rank_reg, hit_rank_next;
    logic                  free_found_reg, free_found_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    logic                  any_reg, any_next;
    logic [IW-1:0]         worst_idx_reg, worst_idx_next;
    logic [IW-1:0]         worst_rank_reg, worst_rank_next;
    logic [IW-1:0]         slot_reg, slot_next;
    logic [CW-1:0]         old_rank_reg, old_rank_next;
    logic                  found_reg, found_next;
    logic                  evicted_reg, evicted_next;
    logic                  rv_pending_reg, rv_pending_next;
    logic [IN_VALUE_BITS-1:0] rv_reg, rv_next;

    logic [KEY_BITS-1:0]      key_in;
    logic [VALUE_BITS-1:0]    val_in;
    logic [IN_VALUE_BITS-1:0] rv_ext;

    logic [KEY_BITS-1:0]   key_rdata;
    logic [VALUE_BITS-1:0] val_rdata;
    logic [IW-1:0]         rank_rdata;

    logic                  key_we, val_we, rank_we;
    logic [IW-1:0]         rank_waddr, rank_wdata, dec_slot;
    logic [CAPW-1:0]       cap_eff;
    logic                  cfg_we;
    logic                  accept;

    for (genvar b = 0; b < KEY_BITS; b++) begin : g_key
        if (b < IN_KEY_BITS) begin : g_in
            assign key_in[b] = s_data.lookup_key[b];
        end else begin : g_zero
            assign key_in[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < VALUE_BITS; b++) begin : g_val
        if (b < IN_VALUE_BITS) begin : g_in
            assign val_in[b] = s_data.write_value[b];
        end else begin : g_zero
            assign val_in[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < IN_VALUE_BITS; b++) begin : g_rv
        if (b < VALUE_BITS) begin : g_bit
            assign rv_ext[b] = val_rdata[b];
        end else begin : g_sign
            assign rv_ext[b] = val_rdata[VALUE_BITS-1];
        end
    end

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CAPW'(1);
        end else if (CAPW'(cap_reg) > CAPW'(ENTRIES)) begin
            cap_eff = CAPW'(ENTRIES);
        end else begin
            cap_eff = CAPW'(cap_reg);
        end
    end

    assign cfg_we  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_CAPACITY) ? PDATA_BITS'(cap_reg) : '0;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        if (hit_found_reg) begin
            dec_slot = hit_idx_reg;
        end else if (free_found_reg && (CAPW'(occ_reg) < cap_eff)) begin
            dec_slot = free_idx_reg;
        end else begin
            dec_slot = worst_idx_reg;
        end
    end

    assign key_we = (state_reg == ST_DECIDE) && (mode_reg == MODE_PUT) && !hit_found_reg;
    assign val_we = (state_reg == ST_DECIDE) && (mode_reg == MODE_PUT);

    always_comb begin
        rank_we    = 1'b0;
        rank_waddr = pipe_idx_reg;
        rank_wdata = rank_rdata + 1'b1;
        if ((state_reg == ST_PROM || state_reg == ST_PROM_END) && pipe_valid_reg
            && valid_reg[pipe_idx_reg] && (pipe_idx_reg != slot_reg)
            && (CW'(rank_rdata) < old_rank_reg)) begin
            rank_we = 1'b1;
        end else if (state_reg == ST_RANK0) begin
            rank_we    = 1'b1;
            rank_waddr = slot_reg;
            rank_wdata = '0;
        end
    end

    always_comb begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        pipe_valid_next = (state_reg == ST_SCAN) || (state_reg == ST_PROM);
        pipe_idx_next   = rd_idx_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        cap_next        = cfg_we ? pwdata[CAP_BITS-1:0] : cap_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        any_next        = any_reg;
        worst_idx_next  = worst_idx_reg;
        worst_rank_next = worst_rank_reg;
        slot_next       = slot_reg;
        old_rank_next   = old_rank_reg;
        found_next      = found_reg;
        evicted_next    = evicted_reg;
        rv_pending_next = 1'b0;
        rv_next         = rv_pending_reg ? rv_ext : rv_reg;

        // compare stage of the key scan
        if ((state_reg == ST_SCAN || state_reg == ST_SCAN_END) && pipe_valid_reg) begin
            if (valid_reg[pipe_idx_reg] && (key_rdata == key_reg) && !hit_found_reg) begin
                hit_found_next = 1'b1;
                hit_idx_next   = pipe_idx_reg;
                hit_rank_next  = rank_rdata;
            end
            if (!valid_reg[pipe_idx_reg] && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = pipe_idx_reg;
            end
            if (valid_reg[pipe_idx_reg] && (!any_reg || (rank_rdata > worst_rank_reg))) begin
                any_next        = 1'b1;
                worst_idx_next  = pipe_idx_reg;
                worst_rank_next = rank_rdata;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_next       = s_data.mode;
                    key_next        = key_in;
                    val_next        = val_in;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    any_next        = 1'b0;
                    found_next      = 1'b0;
                    evicted_next    = 1'b0;
                    rv_next         = '0;
                    rd_idx_next     = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN, ST_PROM: begin
                if (rd_idx_reg == LAST_IDX) begin
                    rd_idx_next = '0;
                    state_next  = (state_reg == ST_SCAN) ? ST_SCAN_END : ST_PROM_END;
                end else begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            ST_SCAN_END: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                slot_next  = dec_slot;
                state_next = ST_PROM;
                if (hit_found_reg) begin
                    found_next      = 1'b1;
                    old_rank_next   = CW'(hit_rank_reg);
                    rv_pending_next = (mode_reg == MODE_GET);
                end else if (mode_reg == MODE_GET) begin
                    state_next = ST_DONE;
                end else if (free_found_reg && (CAPW'(occ_reg) < cap_eff)) begin
                    valid_next[free_idx_reg] = 1'b1;
                    occ_next      = occ_reg + 1'b1;
                    old_rank_next = occ_reg + 1'b1;
                end else begin
                    evicted_next  = 1'b1;
                    old_rank_next = CW'(worst_rank_reg);
                end
            end
            ST_PROM_END: begin
                state_next = ST_RANK0;
            end
            ST_RANK0: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.found      = found_reg;
                    m_data_next.read_value = rv_reg;
                    m_data_next.evicted    = evicted_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pipe_valid_reg <= 1'b0;
            valid_reg      <= '0;
            occ_reg        <= '0;
            cap_reg        <= CAP_RESET;
            m_valid_reg    <= 1'b0;
            rv_pending_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pipe_valid_reg <= pipe_valid_next;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            cap_reg        <= cap_next;
            m_valid_reg    <= m_valid_next;
            rv_pending_reg <= rv_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        pipe_idx_reg   <= pipe_idx_next;
        m_data_reg     <= m_data_next;
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        any_reg        <= any_next;
        worst_idx_reg  <= worst_idx_next;
        worst_rank_reg <= worst_rank_next;
        slot_reg       <= slot_next;
        old_rank_reg   <= old_rank_next;
        found_reg      <= found_next;
        evicted_reg    <= evicted_next;
        rv_reg         <= rv_next;
    end

    lkv_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (dec_slot),
        .wdata (key_reg),
        .raddr (rd_idx_reg),
        .rdata (key_rdata)
    );

    lkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (dec_slot),
        .wdata (val_reg),
        .raddr (hit_idx_reg),
        .rdata (val_rdata)
    );

    lkv_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank_ram (
        .aclk  (aclk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (rd_idx_reg),
        .rdata (rank_rdata)
    );

endmodule

[src/lkv_ram.sv]
module lkv_ram
    import lkv_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/lkv_checker.sv]
`include "lru_key_value_cache_core_defines.svh"

module lkv_checker
    import lkv_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // a stalled result beat holds
    `LKV_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // one item at a time: busy right after an input beat
    `LKV_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // nonzero data only comes from a hit
    `LKV_ASSERT_NOW(a_value_needs_hit, m_valid && (m_data.read_value != 0), m_data.found)

    // eviction only on a miss
    `LKV_ASSERT_NOW(a_evict_on_miss, m_valid && m_data.evicted, !m_data.found)

endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
